/* rtl/core/ad64_pkg.sv */
// ----------------------------------------------------------------------------
// ad64_pkg
// Types and constants for the streaming ASCII decimal to 64-bit integer parser.
// ----------------------------------------------------------------------------
package ad64_pkg;

    localparam int unsigned MAX_CHARS_DEF = 256;
    localparam int unsigned CHAR_W        = 8;
    localparam int unsigned VALUE_W       = 64;
    localparam int unsigned STOP_W        = 9;
    localparam int unsigned CFG_IDX_W     = 1;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

    // Largest magnitude divided by ten and its remainder, per mode.
    localparam logic [VALUE_W-1:0] SGN_MAX_DIV10 = 64'd922337203685477580;
    localparam logic [3:0]         SGN_MAX_MOD10 = 4'd7;
    localparam logic [VALUE_W-1:0] UNS_MAX_DIV10 = 64'd1844674407370955161;
    localparam logic [3:0]         UNS_MAX_MOD10 = 4'd5;

    typedef enum logic [1:0] {
        PH_WS     = 2'd0,
        PH_SIGN   = 2'd1,
        PH_DIGITS = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NODIG   = 2'd1,
        ST_RANGE   = 2'd2,
        ST_INVALID = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIGNED_MODE     = 1'd0,
        CFG_STRICT_TRAILING = 1'd1
    } cfg_index_t;

    function automatic logic is_ws(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_dig(input logic [CHAR_W-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

/* rtl/core/ascii_decimal_to_int64.sv */
// ----------------------------------------------------------------------------
// ascii_decimal_to_int64
// Streaming parser of an ASCII decimal string into a 64-bit integer.
// ----------------------------------------------------------------------------
// The block takes one character per cycle, except while a waiting result
// stalls it; each character passes an input register and the parse step, and
// the result of a string is written to the output register when its final
// character leaves the input register. The per-character step (multiply by ten,
// add, and overflow compare on the 64-bit accumulator) is combinational logic
// between the input register and the parse state. One item leaves only on a
// final character; a waiting result stalls the input only when the next
// final character would need the output register.
// ----------------------------------------------------------------------------
module ascii_decimal_to_int64 #(
    parameter int unsigned MAX_CHARS = ad64_pkg::MAX_CHARS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [ad64_pkg::CHAR_W-1:0]    char_code,
    input  logic                           final_char,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [ad64_pkg::VALUE_W-1:0]   value_bits,
    output logic [1:0]                     status,
    output logic [ad64_pkg::STOP_W-1:0]    stop_index,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ad64_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic                           cfg_data
);
    import ad64_pkg::*;

    localparam int unsigned POS_W = $clog2(MAX_CHARS + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_CHARS);

    logic signed_mode_reg;
    logic strict_trailing_reg;

    logic              stage_valid_reg;
    logic [CHAR_W-1:0] stage_char_reg;
    logic              stage_final_reg;

    phase_t             phase_reg, phase_next;
    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic               neg_reg, neg_next;
    status_t            err_reg, err_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [POS_W-1:0]   stop_reg, stop_next;

    logic               out_valid_reg;
    logic [VALUE_W-1:0] value_reg, value_next;
    status_t            status_reg, status_next;
    logic [STOP_W-1:0]  stop_index_reg, stop_index_next;

    logic advance;

    // A character that ends no string never needs the output register.
    assign advance  = stage_valid_reg && (!stage_final_reg || !out_valid_reg || out_ready);
    assign in_ready = !stage_valid_reg || advance;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            signed_mode_reg     <= 1'b1;
            strict_trailing_reg <= 1'b1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SIGNED_MODE:     signed_mode_reg     <= cfg_data;
                CFG_STRICT_TRAILING: strict_trailing_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            stage_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            stage_char_reg  <= char_code;
            stage_final_reg <= final_char;
        end
    end

    // Parse step for the character held in the input register.
    always_comb
    begin
        logic [3:0]         digit;
        logic [VALUE_W-1:0] max_div;
        logic [3:0]         max_mod;
        logic               take;
        logic               ovf;
        logic               trail_bad;
        logic [VALUE_W-1:0] acc_x10;
        status_t            err_fin;
        logic [POS_W-1:0]   stop_fin;
        logic [STOP_W+POS_W-1:0] stop_ext;

        digit     = stage_char_reg[3:0];
        max_div   = signed_mode_reg ? SGN_MAX_DIV10 : UNS_MAX_DIV10;
        max_mod   = signed_mode_reg ? SGN_MAX_MOD10 : UNS_MAX_MOD10;
        ovf       = (acc_reg > max_div) || ((acc_reg == max_div) && (digit > max_mod));
        acc_x10   = (acc_reg << 3) + (acc_reg << 1);
        trail_bad = strict_trailing_reg && (err_reg == ST_OK) && !is_ws(stage_char_reg);
        take      = 1'b0;

        phase_next = phase_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        err_next   = err_reg;
        stop_next  = stop_reg;
        pos_next   = (pos_reg < POS_MAX) ? pos_reg + POS_W'(1) : POS_MAX;

        unique case (phase_reg)
            PH_WS:
            begin
                if (is_ws(stage_char_reg))
                begin
                end
                else if (stage_char_reg == CH_PLUS
                         || (stage_char_reg == CH_MINUS && signed_mode_reg))
                begin
                    neg_next   = (stage_char_reg == CH_MINUS);
                    phase_next = PH_SIGN;
                end
                else if (is_dig(stage_char_reg))
                begin
                    phase_next = PH_DIGITS;
                    take       = 1'b1;
                end
                else
                begin
                    err_next   = ST_NODIG;
                    phase_next = PH_DONE;
                end
            end
            PH_SIGN:
            begin
                if (is_dig(stage_char_reg))
                begin
                    phase_next = PH_DIGITS;
                    take       = 1'b1;
                end
                else
                begin
                    err_next   = ST_NODIG;
                    phase_next = PH_DONE;
                end
            end
            PH_DIGITS:
            begin
                if (is_dig(stage_char_reg))
                begin
                    take = 1'b1;
                end
                else
                begin
                    stop_next  = pos_reg;
                    phase_next = PH_DONE;
                    if (trail_bad)
                        err_next = ST_INVALID;
                end
            end
            PH_DONE:
            begin
                if (trail_bad)
                    err_next = ST_INVALID;
            end
            default: ;
        endcase

        // Once an error is latched, further digits are consumed but not added.
        if (take && err_reg == ST_OK)
        begin
            if (ovf)
                err_next = ST_RANGE;
            else
                acc_next = acc_x10 + VALUE_W'(digit);
        end

        err_fin  = err_next;
        stop_fin = stop_next;
        if (phase_next == PH_WS || phase_next == PH_SIGN)
            err_fin = ST_NODIG;
        else if (phase_next == PH_DIGITS)
            stop_fin = pos_next;
        // The mode may have changed since the digits went in.
        if (err_fin == ST_OK && signed_mode_reg && acc_next[VALUE_W-1])
            err_fin = ST_RANGE;

        status_next = err_fin;
        if (err_fin != ST_OK)
            value_next = '0;
        else if (signed_mode_reg && neg_next)
            value_next = '0 - acc_next;
        else
            value_next = acc_next;

        stop_ext        = {{STOP_W{1'b0}}, stop_fin};
        stop_index_next = (err_fin == ST_NODIG) ? '0 : stop_ext[STOP_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_WS;
            acc_reg   <= '0;
            neg_reg   <= 1'b0;
            err_reg   <= ST_OK;
            pos_reg   <= '0;
            stop_reg  <= '0;
        end
        else if (advance)
        begin
            if (stage_final_reg)
            begin
                phase_reg <= PH_WS;
                acc_reg   <= '0;
                neg_reg   <= 1'b0;
                err_reg   <= ST_OK;
                pos_reg   <= '0;
                stop_reg  <= '0;
            end
            else
            begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                neg_reg   <= neg_next;
                err_reg   <= err_next;
                pos_reg   <= pos_next;
                stop_reg  <= stop_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && stage_final_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && stage_final_reg)
        begin
            value_reg      <= value_next;
            status_reg     <= status_next;
            stop_index_reg <= stop_index_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign value_bits = value_reg;
    assign status     = status_reg;
    assign stop_index = stop_index_reg;

endmodule
